// ----- src/lgtr_pkg.sv -----
// lgtr_pkg: shared types and constants of the lda gibbs token resampler
// used by lgtr_weight_unit, lda_gibbs_token_resampler_top and the testbench, no dependencies
package lgtr_pkg;

  localparam int WEIGHT_W   = 48;   // unsigned q16.32 topic weight
  localparam int FRAC_W     = 16;   // q0.16 uniform draw
  localparam int PRIOR_W    = 16;   // q8.8 priors
  localparam int TIU_W      = 7;    // topics_in_use register
  localparam int VIU_W      = 13;   // vocab_in_use register
  localparam int DOC_W      = 10;
  localparam int WORD_W     = 12;
  localparam int TOPIC_W    = 6;
  localparam int FIX_SHIFT  = 24;   // weight = nw*ad*2^24/dn
  localparam int CHUNK_W    = 16;   // multiplier digit width
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_RESAMPLE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_BETA  = 2'd1,
    CFG_TIU   = 2'd2,
    CFG_VIU   = 2'd3
  } cfg_idx_e;

endpackage

// ----- src/lgtr_weight_unit.sv -----
// lgtr_weight_unit: iterative weight unit, floor(nw*ad*2^24/dn) saturated to 48 bits
// digit-serial multiply then one restoring divide step per cycle; uses lgtr_pkg
module lgtr_weight_unit #(
  parameter int NW = 33,
  parameter int DW = 34
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NW-1:0]                 nw_i,
  input  logic [NW-1:0]                 ad_i,
  input  logic [DW-1:0]                 dn_i,
  output logic                          done_o,
  output logic [lgtr_pkg::WEIGHT_W-1:0] weight_o
);
  import lgtr_pkg::*;

  localparam int NCH  = (NW + CHUNK_W - 1) / CHUNK_W;
  localparam int AW   = NCH * CHUNK_W;
  localparam int PW   = 2 * NW;
  localparam int HW   = PW - FIX_SHIFT;
  localparam int CMPW = (HW > DW) ? HW : DW;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_CHK, S_DIV} state_e;

  state_e              state_q;
  logic [5:0]          cnt_q;
  logic [NW-1:0]       nw_q;
  logic [AW-1:0]       a_q;
  logic [DW-1:0]       dn_q;
  logic [PW-1:0]       p_q;
  logic [DW-1:0]       r_q;
  logic [FIX_SHIFT-1:0] l_q;
  logic [WEIGHT_W-1:0] q_q;
  logic                done_q;
  logic [WEIGHT_W-1:0] weight_q;

  logic [PW-1:0]       prod;
  logic [HW-1:0]       hi;
  logic                sat;
  logic                bit_in;
  logic [DW:0]         rr;
  logic                ge;

  always_comb begin
    prod   = PW'(nw_q) * PW'(a_q[AW-1 -: CHUNK_W]);
    hi     = p_q[PW-1:FIX_SHIFT];
    sat    = CMPW'(hi) >= CMPW'(dn_q);
    bit_in = (cnt_q < 6'(FIX_SHIFT)) ? l_q[FIX_SHIFT-1] : 1'b0;
    rr     = {r_q, bit_in};
    ge     = rr >= {1'b0, dn_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      nw_q     <= '0;
      a_q      <= '0;
      dn_q     <= '0;
      p_q      <= '0;
      r_q      <= '0;
      l_q      <= '0;
      q_q      <= '0;
      weight_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            nw_q    <= nw_i;
            a_q     <= AW'(ad_i);
            dn_q    <= dn_i;
            p_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // most significant digit first
          p_q <= (p_q << CHUNK_W) + prod;
          a_q <= a_q << CHUNK_W;
          if (cnt_q == 6'(NCH - 1)) begin
            state_q <= S_CHK;
          end
          cnt_q <= cnt_q + 6'd1;
        end
        S_CHK: begin
          if (p_q == '0) begin
            weight_q <= '0;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else if (sat) begin
            // quotient would not fit, also covers zero denominator
            weight_q <= WEIGHT_MAX;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            r_q     <= DW'(hi);
            l_q     <= p_q[FIX_SHIFT-1:0];
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          l_q <= l_q << 1;
          if (ge) begin
            r_q <= DW'(rr - {1'b0, dn_q});
          end else begin
            r_q <= DW'(rr);
          end
          q_q <= {q_q[WEIGHT_W-2:0], ge};
          if (cnt_q == 6'(WEIGHT_W - 1)) begin
            weight_q <= {q_q[WEIGHT_W-2:0], ge};
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
          cnt_q <= cnt_q + 6'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign weight_o = weight_q;

endmodule

// ----- src/lda_gibbs_token_resampler_top.sv -----
// lda_gibbs_token_resampler_top: collapsed gibbs token step for lda
// count memories, sequencer and scan; uses lgtr_pkg and lgtr_weight_unit
//
// After reset the block runs a clearing pass over the count memories, one entry
// a cycle, over 2^max(log2(VOCAB)+log2(TOPICS), log2(DOCS)+log2(TOPICS))
// addresses (262144 with the defaults); configuration writes are taken meanwhile,
// no item. Indexes are first reduced modulo DOCS, VOCAB and TOPICS by a
// reciprocal multiply. A load item adds the token under its topic and shows
// that topic as its result. A resample item removes the token, weighs each topic
// in use with the shared weight unit (3 multiply digits, a check and 48 divide
// steps, without the divide steps when the weight is zero or saturates), sums,
// scales the draw, scans topics downward and adds the token back under the
// picked topic. Most of its time goes to the one-bit-a-cycle divider in the
// weight unit. The result sits in an output register, so the next item is taken
// while it waits.
module lda_gibbs_token_resampler_top #(
  parameter int TOPICS      = 64,
  parameter int VOCAB       = 4096,
  parameter int DOCS        = 1024,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // doc_index[9:0], word_index[21:10], current_topic[27:22], random_fraction[43:28]
  input  logic [lgtr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation[0]
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sampled_topic[5:0]
  output logic [lgtr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lgtr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lgtr_pkg::PRIOR_W-1:0]      cfg_data_i
);
  import lgtr_pkg::*;

  localparam int KB   = $clog2(TOPICS);
  localparam int WB   = $clog2(VOCAB);
  localparam int DB   = (DOCS > 1) ? $clog2(DOCS) : 1;
  localparam int WAW  = WB + KB;
  localparam int DAW  = DB + KB;
  localparam int CAW  = (WAW > DAW) ? WAW : DAW;
  localparam int CW   = COUNT_WIDTH;
  localparam int NW   = CW + 9;
  localparam int DW   = ((CW + 8 > 33) ? CW + 8 : 33) + 1;
  localparam int KTW  = $clog2(TOPICS + 1);
  localparam int VTW  = $clog2(VOCAB + 1);
  localparam int SUMW = WEIGHT_W + KTW;

  // reciprocal constants, floor(x/C) = (x*M) >> S for every x of the field
  localparam int DSH = DOC_W + $clog2(DOCS);
  localparam int WSH = WORD_W + $clog2(VOCAB);
  localparam int ZSH = TOPIC_W + $clog2(TOPICS);
  localparam longint unsigned DMUL = ((64'd1 << DSH) + 64'(DOCS) - 64'd1) / 64'(DOCS);
  localparam longint unsigned WMUL = ((64'd1 << WSH) + 64'(VOCAB) - 64'd1) / 64'(VOCAB);
  localparam longint unsigned ZMUL = ((64'd1 << ZSH) + 64'(TOPICS) - 64'd1) / 64'(TOPICS);
  localparam int DPW = 2 * DOC_W + 2;
  localparam int WPW = 2 * WORD_W + 2;
  localparam int ZPW = 2 * TOPIC_W + 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_RD_CUR, S_WB_CUR, S_WT_RD, S_WT_GO,
    S_WT_WAIT, S_SCALE, S_SCAN_RD, S_SCAN_CHK, S_ADD, S_OUT
  } state_e;

  state_e               state_q;
  logic [CAW-1:0]       clr_q;
  logic [3:0]           step_q;
  logic                 op_q;
  logic                 add_q;      // add back rather than remove
  logic [DOC_W-1:0]     d_q;
  logic [WORD_W-1:0]    w_q;
  logic [TOPIC_W-1:0]   z_q;
  logic [DOC_W-1:0]     dq_q;
  logic [WORD_W-1:0]    wq_q;
  logic [TOPIC_W-1:0]   zq_q;
  logic [FRAC_W-1:0]    frac_q;
  logic [KB-1:0]        cur_q;
  logic [KTW-1:0]       k_q;
  logic [KTW-1:0]       kt_q;
  logic [DW-1:0]        bv_q;
  logic [SUMW-1:0]      sum_q;
  logic [SUMW-1:0]      u_q;
  logic [SUMW-1:0]      suf_q;
  logic                 m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic [PRIOR_W-1:0]   alpha_q;
  logic [PRIOR_W-1:0]   beta_q;
  logic [TIU_W-1:0]     tiu_q;
  logic [VIU_W-1:0]     viu_q;

  // count memories and weight store
  logic [CW-1:0]        word_mem [2**WAW];
  logic [CW-1:0]        doc_mem  [2**DAW];
  logic [CW-1:0]        tot_mem  [2**KB];
  logic [WEIGHT_W-1:0]  wgt_mem  [2**KB];
  logic [CW-1:0]        wc_q, dc_q, tc_q;
  logic [WEIGHT_W-1:0]  wr_q;

  // combinational
  logic [DPW-1:0]       d_prod;
  logic [WPW-1:0]       w_prod;
  logic [ZPW-1:0]       z_prod;
  logic [DOC_W-1:0]     d_quo, d_red;
  logic [WORD_W-1:0]    w_quo, w_red;
  logic [TOPIC_W-1:0]   z_quo, z_red;
  logic [63:0]          d_ext, w_ext, cur_ext;
  logic [31:0]          kt_full, vt_full;
  logic [VTW-1:0]       vt;
  logic [KB-1:0]        tsel;
  logic [WAW-1:0]       waddr;
  logic [DAW-1:0]       daddr;
  logic [KB-1:0]        taddr;
  logic                 clearing;
  logic                 cnt_we;
  logic [CW-1:0]        wc_new, dc_new, tc_new;
  logic [KTW-1:0]       km1;
  logic [NW-1:0]        nw, ad;
  logic [DW-1:0]        dn;
  logic                 wu_start, wu_done;
  logic [WEIGHT_W-1:0]  wu_weight;
  logic [SUMW+FRAC_W-1:0] scaled;
  logic [SUMW-1:0]      suf_d;
  logic                 out_free;

  function automatic logic [CW-1:0] cnt_upd(input logic [CW-1:0] c, input logic add);
    logic [CW-1:0] r;
    r = c;
    if (add) begin
      if (c != {CW{1'b1}}) r = c + CW'(1);
    end else begin
      if (c != '0) r = c - CW'(1);
    end
    return r;
  endfunction

  always_comb begin
    // index reduction: quotient by reciprocal, then remainder from the stored quotient
    d_prod = DPW'(d_q) * DPW'(DMUL);
    w_prod = WPW'(w_q) * WPW'(WMUL);
    z_prod = ZPW'(z_q) * ZPW'(ZMUL);
    d_quo  = DOC_W'(d_prod >> DSH);
    w_quo  = WORD_W'(w_prod >> WSH);
    z_quo  = TOPIC_W'(z_prod >> ZSH);
    d_red  = DOC_W'(32'(d_q) - 32'(dq_q) * 32'(DOCS));
    w_red  = WORD_W'(32'(w_q) - 32'(wq_q) * 32'(VOCAB));
    z_red  = TOPIC_W'(32'(z_q) - 32'(zq_q) * 32'(TOPICS));
    d_ext   = 64'(d_q);
    w_ext   = 64'(w_q);
    cur_ext = 64'(cur_q);

    // clamp the topic and vocabulary registers
    if (tiu_q == '0)                 kt_full = 32'd1;
    else if (32'(tiu_q) > TOPICS)    kt_full = 32'(TOPICS);
    else                             kt_full = 32'(tiu_q);
    if (viu_q == '0)                 vt_full = 32'd1;
    else if (32'(viu_q) > VOCAB)     vt_full = 32'(VOCAB);
    else                             vt_full = 32'(viu_q);
    vt = VTW'(vt_full);

    clearing = (state_q == S_CLEAR);
    tsel  = (state_q == S_WT_RD) ? KB'(k_q) : cur_q;
    waddr = clearing ? clr_q[WAW-1:0] : {w_ext[WB-1:0], tsel};
    daddr = clearing ? clr_q[DAW-1:0] : {d_ext[DB-1:0], tsel};
    taddr = clearing ? clr_q[KB-1:0]  : tsel;
    cnt_we = clearing || (state_q == S_WB_CUR);
    wc_new = clearing ? '0 : cnt_upd(wc_q, add_q);
    dc_new = clearing ? '0 : cnt_upd(dc_q, add_q);
    tc_new = clearing ? '0 : cnt_upd(tc_q, add_q);

    km1 = k_q - KTW'(1);

    // weight operands, all scaled by 256
    nw = (NW'(wc_q) << 8) + NW'(beta_q);
    ad = (NW'(dc_q) << 8) + NW'(alpha_q);
    dn = (DW'(tc_q) << 8) + bv_q;
    wu_start = (state_q == S_WT_GO);

    scaled = (SUMW+FRAC_W)'(sum_q) * (SUMW+FRAC_W)'(frac_q);
    suf_d  = suf_q + SUMW'(wr_q);
    out_free = !m_valid_q || m_axis_tready;
  end

  // count memories: one address, registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      word_mem[waddr] <= wc_new;
      doc_mem[daddr]  <= dc_new;
      tot_mem[taddr]  <= tc_new;
    end
    wc_q <= word_mem[waddr];
    dc_q <= doc_mem[daddr];
    tc_q <= tot_mem[taddr];
  end

  // weight store
  always_ff @(posedge clk_i) begin
    if (state_q == S_WT_WAIT && wu_done) begin
      wgt_mem[KB'(k_q)] <= wu_weight;
    end
    wr_q <= wgt_mem[km1[KB-1:0]];
  end

  lgtr_weight_unit #(
    .NW (NW),
    .DW (DW)
  ) u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (wu_start),
    .nw_i     (nw),
    .ad_i     (ad),
    .dn_i     (dn),
    .done_o   (wu_done),
    .weight_o (wu_weight)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 16'd26;
      beta_q  <= 16'd26;
      tiu_q   <= 7'd64;
      viu_q   <= 13'd4096;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_BETA:  beta_q  <= cfg_data_i;
        CFG_TIU:   tiu_q   <= cfg_data_i[TIU_W-1:0];
        CFG_VIU:   viu_q   <= cfg_data_i[VIU_W-1:0];
        default:   ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      step_q    <= '0;
      op_q      <= 1'b0;
      add_q     <= 1'b0;
      d_q       <= '0;
      w_q       <= '0;
      z_q       <= '0;
      dq_q      <= '0;
      wq_q      <= '0;
      zq_q      <= '0;
      frac_q    <= '0;
      cur_q     <= '0;
      k_q       <= '0;
      kt_q      <= '0;
      bv_q      <= '0;
      sum_q     <= '0;
      u_q       <= '0;
      suf_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CAW'(1);
          if (clr_q == {CAW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser;
            d_q     <= s_axis_tdata[9:0];
            w_q     <= s_axis_tdata[21:10];
            z_q     <= s_axis_tdata[27:22];
            frac_q  <= s_axis_tdata[43:28];
            step_q  <= 4'd1;
            state_q <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (step_q != '0) begin
            dq_q   <= d_quo;
            wq_q   <= w_quo;
            zq_q   <= z_quo;
            step_q <= step_q - 4'd1;
          end else begin
            d_q     <= d_red;
            w_q     <= w_red;
            z_q     <= z_red;
            cur_q   <= KB'(64'(z_red));
            add_q   <= (op_e'(op_q) == OP_LOAD);
            kt_q    <= KTW'(kt_full);
            bv_q    <= DW'(beta_q) * DW'(vt);
            state_q <= S_RD_CUR;
          end
        end
        S_RD_CUR: state_q <= S_WB_CUR;
        S_WB_CUR: begin
          if (add_q) begin
            state_q <= S_OUT;
          end else begin
            // token removed, weigh every topic in use
            k_q     <= '0;
            sum_q   <= '0;
            state_q <= S_WT_RD;
          end
        end
        S_WT_RD: state_q <= S_WT_GO;
        S_WT_GO: state_q <= S_WT_WAIT;
        S_WT_WAIT: begin
          if (wu_done) begin
            sum_q <= sum_q + SUMW'(wu_weight);
            if (k_q == kt_q - KTW'(1)) begin
              state_q <= S_SCALE;
            end else begin
              k_q     <= k_q + KTW'(1);
              state_q <= S_WT_RD;
            end
          end
        end
        S_SCALE: begin
          u_q     <= scaled[SUMW+FRAC_W-1:FRAC_W];
          k_q     <= kt_q;
          suf_q   <= '0;
          state_q <= S_SCAN_RD;
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          // suffix sum from the top topic down
          suf_q <= suf_d;
          if (suf_d > u_q) begin
            cur_q   <= km1[KB-1:0];
            state_q <= S_ADD;
          end else if (k_q == KTW'(1)) begin
            cur_q   <= '0;
            state_q <= S_ADD;
          end else begin
            k_q     <= km1;
            state_q <= S_SCAN_RD;
          end
        end
        S_ADD: begin
          add_q   <= 1'b1;
          state_q <= S_RD_CUR;
        end
        S_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_DATA_W'(cur_ext[TOPIC_W-1:0]);
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ----- tb/lgtr_sample_checker.sv -----
// lgtr_sample_checker: watches the item, result and register channels of the
// lda gibbs token resampler, predicts each sampled topic and compares; uses lgtr_pkg
module lgtr_sample_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [lgtr_pkg::IN_DATA_W-1:0]  s_data_i,
  input  logic                            s_user_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [lgtr_pkg::OUT_DATA_W-1:0] m_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lgtr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lgtr_pkg::PRIOR_W-1:0]    cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lgtr_pkg::*;

  localparam int NTOP = 64;
  localparam int NVOC = 4096;
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  bit [23:0] word_cnt [NVOC*NTOP];
  bit [23:0] doc_cnt  [1024*NTOP];
  bit [23:0] tot_cnt  [NTOP];
  bit [WEIGHT_W-1:0] weight_tab [NTOP];

  logic [15:0] alpha_q = 16'd26;
  logic [15:0] beta_q  = 16'd26;
  logic [6:0]  topics_reg = 7'd64;
  logic [12:0] vocab_reg  = 13'd4096;

  logic [5:0] topic_q [$];
  int         fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = topic_q.size();

  function automatic void bump(int unsigned wi, int unsigned di, int unsigned k, bit up);
    if (up) begin
      if (word_cnt[wi*NTOP+k] != CNT_MAX) word_cnt[wi*NTOP+k]++;
      if (doc_cnt[di*NTOP+k] != CNT_MAX) doc_cnt[di*NTOP+k]++;
      if (tot_cnt[k] != CNT_MAX) tot_cnt[k]++;
    end else begin
      if (word_cnt[wi*NTOP+k] != 0) word_cnt[wi*NTOP+k]--;
      if (doc_cnt[di*NTOP+k] != 0) doc_cnt[di*NTOP+k]--;
      if (tot_cnt[k] != 0) tot_cnt[k]--;
    end
  endfunction

  // one gibbs step on the shadow tables, returns the topic the block should give
  function automatic logic [5:0] gibbs_step(op_e op, int unsigned di, int unsigned wi,
                                            int unsigned zi, logic [15:0] frac);
    int unsigned  kt, vt, pick;
    logic [63:0]  nw, dn, ad, wsum, suf, draw;
    logic [127:0] num, quo;
    if (op == OP_LOAD) begin
      bump(wi, di, zi, 1'b1);
      return zi[5:0];
    end
    bump(wi, di, zi, 1'b0);
    kt = (topics_reg == 0) ? 1 : (topics_reg > NTOP) ? NTOP : topics_reg;
    vt = (vocab_reg == 0) ? 1 : (vocab_reg > NVOC) ? NVOC : vocab_reg;
    wsum = 0;
    for (int k = 0; k < kt; k++) begin
      nw  = (64'(word_cnt[wi*NTOP+k]) << 8) + beta_q;
      dn  = (64'(tot_cnt[k]) << 8) + 64'(beta_q) * vt;
      ad  = (64'(doc_cnt[di*NTOP+k]) << 8) + alpha_q;
      num = (128'(nw) * 128'(ad)) << FIX_SHIFT;
      if (num == 0) weight_tab[k] = '0;
      else if (dn == 0) weight_tab[k] = WEIGHT_MAX;
      else begin
        quo = num / dn;
        weight_tab[k] = (quo > 128'(WEIGHT_MAX)) ? WEIGHT_MAX : quo[WEIGHT_W-1:0];
      end
      wsum += weight_tab[k];
    end
    num  = (128'(wsum) * 128'(frac)) >> FRAC_W;
    draw = num[63:0];
    // scan from the top topic down, first suffix sum above the draw wins
    pick = 0;
    suf  = 0;
    for (int k = kt; k > 0; k--) begin
      suf += weight_tab[k-1];
      if (suf > draw) begin
        pick = k - 1;
        break;
      end
    end
    bump(wi, di, pick, 1'b1);
    return pick[5:0];
  endfunction

  always @(posedge clk_i) begin
    logic [5:0] want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ALPHA: alpha_q = cfg_data_i;
          CFG_BETA:  beta_q = cfg_data_i;
          CFG_TIU:   topics_reg = cfg_data_i[6:0];
          CFG_VIU:   vocab_reg = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i)
        topic_q.push_back(gibbs_step(op_e'(s_user_i), s_data_i[9:0], s_data_i[21:10],
                                     s_data_i[27:22], s_data_i[43:28]));
      if (m_valid_i && m_ready_i) begin
        if (topic_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item, topic %0d", m_data_i);
        end else begin
          want = topic_q.pop_front();
          if (m_data_i !== {2'b00, want}) begin
            fails++;
            if (fails <= 10)
              $display("topic mismatch: expected %0d, got %0d", want, m_data_i);
          end
        end
      end
    end
  end

endmodule

// ----- tb/lda_gibbs_token_resampler_top_tb.sv -----
// lda_gibbs_token_resampler_top_tb: stimulus and verdict for the token resampler
// drives items in phases of register settings; checking lives in lgtr_sample_checker
module lda_gibbs_token_resampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgtr_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_DATA_W-1:0]   s_data = '0;
  logic                   s_user = 1'b0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_ALPHA;
  logic [PRIOR_W-1:0]     cfg_data = '0;
  int                     fail_count;
  int                     pending;

  // sender pacing and receiver stall style, changed per phase
  bit no_gaps = 1'b1;
  bit no_stalls = 1'b1;
  int stall_left = 0;
  int tiu_eff = 64;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lda_gibbs_token_resampler_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  lgtr_sample_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_user_i     (s_user),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: either always ready, or stalled at random
  always @(posedge clk_i) begin
    if (no_stalls) begin
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else if ($urandom_range(7) == 0) begin
      stall_left <= $urandom_range(20, 1);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // register write, valid dropped for a cycle so writes never chain in one step
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // item send; valid stays high across a burst, gap opens only between bursts
  int burst_left = 0;
  task automatic send_item(op_e op, logic [9:0] doc, logic [11:0] word,
                           logic [5:0] topic, logic [15:0] frac);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(10, 1);
      gap = no_gaps ? 0 : $urandom_range(6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {4'b0000, frac, topic, word, doc};
    do @(posedge clk_i); while (!s_ready);
  endtask

  // idle point: every result back, then margin for the output register
  task automatic drain();
    s_valid <= 1'b0;
    burst_left = 0;
    // let the checker log the last accepted item before pending is read
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_item();
    op_e         op;
    logic [9:0]  doc;
    logic [11:0] word;
    logic [5:0]  topic;
    logic [15:0] frac;
    op = ($urandom_range(1) == 0) ? OP_LOAD : OP_RESAMPLE;
    // a small pool of documents and words builds real counts, the rest is spread wide
    doc  = ($urandom_range(3) != 0) ? 10'($urandom_range(3)) : 10'($urandom);
    word = ($urandom_range(3) != 0) ? 12'($urandom_range(7)) : 12'($urandom);
    topic = ($urandom_range(4) != 0) ? 6'($urandom_range(tiu_eff - 1)) : 6'($urandom);
    case ($urandom_range(9))
      0:       frac = 16'h0000;
      1:       frac = 16'hFFFF;
      default: frac = 16'($urandom);
    endcase
    send_item(op, doc, word, topic, frac);
  endtask

  // register settings per phase: alpha, beta, topics_in_use, vocab_in_use, item count
  localparam int NPH = 9;
  int ph_alpha [NPH] = '{0,     65535, 256,  512,  0,    26,   1000, 7,    65535};
  int ph_beta  [NPH] = '{0,     65535, 13,   100,  0,    26,   5,    300,  1};
  int ph_tiu   [NPH] = '{1,     0,     4,    8,    6,    3,    2,    127,  16};
  int ph_viu   [NPH] = '{1,     0,     8191, 1000, 4096, 2000, 50,   4096, 1};
  int ph_items [NPH] = '{60,    60,    200,  200,  150,  200,  150,  12,   70};

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset settings, 64 topics
    send_item(OP_LOAD, 10'd0, 12'd0, 6'd0, 16'h0000);
    send_item(OP_LOAD, 10'd1023, 12'd4095, 6'd63, 16'hFFFF);
    send_item(OP_LOAD, 10'd0, 12'd0, 6'd5, 16'h1234);
    send_item(OP_LOAD, 10'd0, 12'd0, 6'd5, 16'h8000);
    send_item(OP_RESAMPLE, 10'd0, 12'd0, 6'd5, 16'h0000);
    send_item(OP_RESAMPLE, 10'd0, 12'd0, 6'd5, 16'hFFFF);
    send_item(OP_RESAMPLE, 10'd1023, 12'd4095, 6'd63, 16'h8000);
    // removal from an empty topic must not wrap the counters
    send_item(OP_RESAMPLE, 10'd7, 12'd9, 6'd40, 16'h4000);
    send_item(OP_RESAMPLE, 10'h2AA, 12'h555, 6'h2A, 16'hAAAA);
    send_item(OP_LOAD, 10'h155, 12'hAAA, 6'h15, 16'h5555);
    drain();

    // topic out of the range in use still gets removed from its own row
    write_reg(CFG_TIU, 16'd2);
    tiu_eff = 2;
    send_item(OP_LOAD, 10'd3, 12'd3, 6'd50, 16'h0);
    send_item(OP_RESAMPLE, 10'd3, 12'd3, 6'd50, 16'h7000);
    send_item(OP_RESAMPLE, 10'd3, 12'd3, 6'd63, 16'hFFFF);
    drain();

    for (int p = 0; p < NPH; p++) begin
      write_reg(CFG_ALPHA, 16'(ph_alpha[p]));
      write_reg(CFG_BETA, 16'(ph_beta[p]));
      write_reg(CFG_TIU, 16'(ph_tiu[p]));
      write_reg(CFG_VIU, 16'(ph_viu[p]));
      tiu_eff = (ph_tiu[p] == 0) ? 1 : (ph_tiu[p] > 64) ? 64 : ph_tiu[p];
      no_gaps   = (p % 3 == 0);
      no_stalls = (p % 4 == 1);
      for (int i = 0; i < ph_items[p]; i++) random_item();
      // hold the sender until everything is back before new settings
      drain();
    end

    no_stalls = 1'b1;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit, well beyond clearing pass plus the slowest item schedule
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
